/* rtl/sha1bs_pkg.sv */
package sha1bs_pkg;

	localparam int BlkBytes = 64;
	localparam int BlkBits  = 8 * BlkBytes;
	localparam int Rounds   = 80;
	localparam int LenPos   = 56;
	localparam int Words    = 5;
	localparam int MsgBits  = 61;
	localparam int OutBits  = 40;

	localparam logic [7:0] PadMark = 8'h80;

	localparam logic [Words-1:0][31:0] InitVec = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RND  = 5'b00010,
		ST_ADD  = 5'b00100,
		ST_PAD  = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	// Round constant for round number rnd (0 to 79).
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	// Round function: choose, parity, majority, parity.
	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

/* rtl/sha1_byte_stream_hasher.sv */
// Streaming SHA-1 hasher.
// Input items arrive on the s_ group. With s_tuser low, an item appends the byte
// in s_tdata to the message. With s_tuser high, the item finishes the message:
// the block pads it, compresses the last block or two and then sends the five
// digest words on the m_ group, most significant word first, with m_tlast on
// the fifth word. After the fifth word is taken, the hash words return to the
// initial vector and the next item starts a new message.
// Flow: an append item is accepted whenever the block is idle, and every 64th
// byte of the padded message starts a compression (80 rounds of one shared
// round unit, then a step that adds the working words into the hash words).
// A finish item feeds 9 to 72 pad bytes, one per cycle while no block
// compresses, which includes one or two block compressions. s_tready is low
// while a block compresses, while padding runs and while the digest goes
// out.
// If the receiver stalls, the current digest word is held on m_tdata and the
// block waits; no item is accepted until all five words have been taken.
// Reset clears the sequencer, the byte position and the length counter and
// loads the initial vector, so the first message may start right after reset.
module sha1_byte_stream_hasher
	import sha1bs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tuser,   // [0] kind: 0 append byte, 1 finish
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OutBits-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic               m_tlast
);

	st_t                 state_q;
	logic [5:0]          pos_q;
	logic [MsgBits-1:0]  msg_q;
	logic                pad_q;       // a finish item is being padded
	logic                mark_q;      // the 0x80 byte is still to be placed
	logic                len_run_q;   // length bytes have started
	logic [6:0]          rnd_q;
	logic [2:0]          out_idx_q;
	logic [31:0]         h_q [Words];

	// Block window: 16 words, oldest word of the schedule in the top 32 bits.
	logic [BlkBits-1:0]  blk_q;
	logic [63:0]         len_q;
	logic [31:0]         a_q, b_q, c_q, d_q, e_q;

	logic                in_acc;
	logic                out_acc;
	logic                put_en;
	logic                len_byte;
	logic [7:0]          put_byte;
	logic [31:0]         w_cur;
	logic [31:0]         w_mix;
	logic [31:0]         w_new;
	logic [31:0]         t_sum;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'd0, out_idx_q, h_q[0]};
	assign m_tlast  = (out_idx_q == 3'(Words - 1));

	// Once the length field has started, every pad byte comes from the length.
	assign len_byte = !mark_q && (len_run_q || (pos_q == 6'(LenPos)));

	always_comb begin
		put_en   = 1'b0;
		put_byte = 8'd0;
		if (state_q == ST_IDLE) begin
			put_en   = in_acc && !s_tuser;
			put_byte = s_tdata;
		end else if (state_q == ST_PAD) begin
			put_en = 1'b1;
			if (mark_q) begin
				put_byte = PadMark;
			end else if (len_byte) begin
				put_byte = len_q[63:56];
			end
		end
	end

	// Shared round unit: the message schedule expands in place in the window.
	assign w_cur = blk_q[BlkBits-1 -: 32];
	assign w_mix = blk_q[32*2 +: 32] ^ blk_q[32*7 +: 32] ^ blk_q[32*13 +: 32] ^ w_cur;
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ round_k(rnd_q) + w_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			msg_q     <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			len_run_q <= 1'b0;
			rnd_q     <= '0;
			out_idx_q <= '0;
			for (int i = 0; i < Words; i++) begin
				h_q[i] <= InitVec[i];
			end
		end else begin
			if (state_q == ST_IDLE && in_acc) begin
				if (s_tuser) begin
					pad_q  <= 1'b1;
					mark_q <= 1'b1;
					state_q <= ST_PAD;
				end else begin
					msg_q <= msg_q + MsgBits'(1);
				end
			end
			if (put_en) begin
				pos_q <= pos_q + 6'd1;
				if (state_q == ST_PAD) begin
					if (mark_q) begin
						mark_q <= 1'b0;
					end else if (len_byte) begin
						len_run_q <= 1'b1;
					end
				end
				if (pos_q == 6'(BlkBytes - 1)) begin
					rnd_q   <= '0;
					state_q <= ST_RND;
				end
			end
			if (state_q == ST_RND) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(Rounds - 1)) begin
					state_q <= ST_ADD;
				end
			end
			if (state_q == ST_ADD) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
				if (!pad_q) begin
					state_q <= ST_IDLE;
				end else if (len_run_q) begin
					out_idx_q <= '0;
					state_q   <= ST_OUT;
				end else begin
					state_q <= ST_PAD;
				end
			end
			if (out_acc) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == 3'(Words - 1)) begin
					for (int i = 0; i < Words; i++) begin
						h_q[i] <= InitVec[i];
					end
					msg_q     <= '0;
					pad_q     <= 1'b0;
					len_run_q <= 1'b0;
					out_idx_q <= '0;
					state_q   <= ST_IDLE;
				end else begin
					for (int i = 0; i < Words - 1; i++) begin
						h_q[i] <= h_q[i+1];
					end
					h_q[Words-1] <= h_q[0];
				end
			end
		end
	end

	// Data path registers: block window, length shifter and working words.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && s_tuser) begin
			len_q <= {msg_q, 3'b000};
		end
		if (put_en) begin
			blk_q <= {blk_q[BlkBits-9:0], put_byte};
			if (state_q == ST_PAD && len_byte) begin
				len_q <= {len_q[55:0], 8'd0};
			end
			if (pos_q == 6'(BlkBytes - 1)) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end
		if (state_q == ST_RND) begin
			blk_q <= {blk_q[BlkBits-33:0], w_new};
			a_q   <= t_sum;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
		end
	end

	// The digest only goes out once the padded message ends on a block boundary.
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pos_q == '0))
		else $error("digest offered while a block is partly filled");

	// Each digest starts with the most significant word.
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (out_idx_q == '0))
		else $error("digest does not start at word zero");

	// Input and output never run together.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest is offered");

	// The round counter stays within one compression.
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> (rnd_q < 7'(Rounds)))
		else $error("round counter out of range");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb
	import sha1bs_pkg::*;
;

	// Item kinds on s_tuser.
	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Digests that are known by heart: the empty message and "abc".
	localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
	localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

	// Generous bound on the whole run, in clock cycles.
	localparam int CYCLE_LIMIT = 1000000;
	// Long receiver hold-off, long enough to back the block up into its input.
	localparam int LONG_HOLD   = 500;
	// Quiet time after the last digest word.
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 220;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	typedef struct packed {
		logic         kind;
		logic [7:0]   data;
		logic         known;
		logic [159:0] digest;
	} stim_row_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'h00;
	logic               s_tuser  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OutBits-1:0] m_tdata;
	logic               m_tlast;

	sha1_byte_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Directed items. A row whose digest is typed in is checked against that value;
	// every other finish row is checked against the software hash below.
	stim_row_t directed_rows [11] = '{
		'{KIND_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},   // empty message straight after reset
		'{KIND_APPEND, 8'h61, 1'b0, 160'h0},
		'{KIND_APPEND, 8'h62, 1'b0, 160'h0},
		'{KIND_APPEND, 8'h63, 1'b0, 160'h0},
		'{KIND_FINISH, 8'h5a, 1'b1, DIGEST_ABC},     // finish data byte must be ignored
		'{KIND_APPEND, 8'h00, 1'b0, 160'h0},         // data byte extremes
		'{KIND_APPEND, 8'hff, 1'b0, 160'h0},
		'{KIND_APPEND, 8'h55, 1'b0, 160'h0},
		'{KIND_APPEND, 8'haa, 1'b0, 160'h0},
		'{KIND_FINISH, 8'hff, 1'b0, 160'h0},
		'{KIND_FINISH, 8'h00, 1'b1, DIGEST_EMPTY}    // back-to-back finish: new empty message
	};

	// Software SHA-1 state that tracks the block.
	logic [31:0] hash_state [Words];
	logic [7:0]  block_bytes [BlkBytes];
	logic [5:0]  fill_pos;
	logic [MsgBits-1:0] msg_len;

	// Digest words still owed by the block, oldest first.
	digest_word_t pending_words [$];

	int errors      = 0;
	int words_taken = 0;
	int cycles      = 0;
	int tx_burst    = 0;
	int rx_burst    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Picks an idle length: mostly none or short, now and then long, and
	// occasionally a burst of several dozen calls with no idling at all.
	function automatic int pick_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void clear_hash();
		for (int i = 0; i < Words; i++)
			hash_state[i] = InitVec[i];
		fill_pos = '0;
		msg_len  = '0;
	endfunction

	// One 80-round compression of the block bytes into the hash state.
	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < Rounds; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] v);
		block_bytes[fill_pos] = v;
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			compress_block();
	endfunction

	// Advances the software hash by one accepted item. For a finish item it pads,
	// returns the digest with word 0 in the top bits and starts a new message.
	function automatic logic [159:0] hash_item(input logic kind, input logic [7:0] data);
		logic [63:0]  bit_len;
		logic [159:0] digest;
		digest = '0;
		if (kind == KIND_APPEND) begin
			absorb_byte(data);
			msg_len = msg_len + 1'b1;
		end else begin
			bit_len = {msg_len, 3'b000};
			absorb_byte(PadMark);
			while (fill_pos != LenPos[5:0])
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[63 - 8*i -: 8]);
			digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
				hash_state[4]};
			clear_hash();
		end
		return digest;
	endfunction

	// Offers one item and holds it until the block takes it. The valid line is
	// only lowered when an idle gap follows, so back-to-back items keep it high.
	task automatic offer_item(input logic kind, input logic [7:0] data, input logic known,
			input logic [159:0] typed);
		logic [159:0] digest;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		digest = hash_item(kind, data);
		if (kind == KIND_FINISH) begin
			if (known)
				digest = typed;
			for (int i = 0; i < Words; i++)
				pending_words.push_back('{digest[159 - 32*i -: 32], 3'(i), i == Words - 1});
		end
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Compares one taken digest word against the oldest one owed.
	task automatic check_word();
		digest_word_t want;
		if (pending_words.size() == 0) begin
			errors++;
			$display("%0t: digest word with none owed: expected nothing, got %h",
				$time, m_tdata);
		end else begin
			want = pending_words.pop_front();
			if (m_tdata[31:0] !== want.word) begin
				errors++;
				$display("%0t: digest_word expected %h got %h", $time, want.word,
					m_tdata[31:0]);
			end
			if (m_tdata[34:32] !== want.idx) begin
				errors++;
				$display("%0t: word_index expected %0d got %0d", $time, want.idx,
					m_tdata[34:32]);
			end
			if (m_tdata[OutBits-1:35] !== '0) begin
				errors++;
				$display("%0t: tdata fill bits expected 0 got %h", $time,
					m_tdata[OutBits-1:35]);
			end
			if (m_tlast !== want.last) begin
				errors++;
				$display("%0t: last expected %b got %b", $time, want.last, m_tlast);
			end
		end
		words_taken++;
	endtask

	// Receiver: checks every taken word and drives m_tready with random stalls.
	// Once the random part is under way it holds off for a long stretch while a
	// digest is waiting, so the block backs up and refuses input items.
	initial begin
		int rx_stall;
		int hold_left;
		bit hold_done;
		rx_stall  = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_word();
			if (!hold_done && m_tvalid && words_taken >= 20) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				rx_stall = pick_gap(rx_burst);
				if (rx_stall > 0) begin
					rx_stall--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Sender: reset, directed table, then random messages.
	initial begin
		int sent;
		int msg_count;
		int msg_bytes;
		int r;
		clear_hash();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].known,
				directed_rows[i].digest);

		// Random messages. Most are short; some sit right at the one-block
		// padding boundary (55 to 65 bytes) so that for some the length spills
		// into a second block, and the first random message always does. The last
		// message is cut short so the item count stays on budget.
		sent      = 0;
		msg_count = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (msg_count == 0)
				msg_bytes = $urandom_range(56, 63);
			else if (r < 5)
				msg_bytes = $urandom_range(0, 6);
			else if (r < 8)
				msg_bytes = $urandom_range(7, 40);
			else
				msg_bytes = $urandom_range(55, 65);
			if (msg_bytes > RANDOM_ITEMS - sent - 1)
				msg_bytes = RANDOM_ITEMS - sent - 1;

			// Once, let the block drain completely before the next message.
			if (msg_count == 3) begin
				s_tvalid <= 1'b0;
				while (pending_words.size() != 0)
					@(posedge clk);
			end

			for (int i = 0; i < msg_bytes; i++)
				offer_item(KIND_APPEND, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
			offer_item(KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
			sent += msg_bytes + 1;
			msg_count++;
		end
		s_tvalid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
